/* sv/lcd_window_pixel_byte_streamer_top_assert.svh */
// Assertion macros for the LCD byte streamer checker.
// Used by lcdws_checker.sv; needs nothing else.
`ifndef LCD_WINDOW_PIXEL_BYTE_STREAMER_TOP_ASSERT_SVH
`define LCD_WINDOW_PIXEL_BYTE_STREAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LCDWS_ASSERT_NOW(label, clk, rst_n, cond, expect_c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expect_c)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LCDWS_ASSERT_NEXT(label, clk, rst_n, cond, expect_c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expect_c)) \
        else $error(msg);

`endif

/* sv/lcdws_pkg.sv */
// Shared types and constants for the LCD window/pixel byte streamer.
// No dependencies; every other file but the assertion header uses it by scoped names.
`default_nettype none

package lcdws_pkg;

    localparam int GLYPH_WORD_BITS_DEF = 32;
    localparam int GLYPH_BITS_CAP      = 32;
    localparam int RUN_MAX_PIXELS      = 32;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [7:0] CMD_COL   = 8'h2A;
    localparam logic [7:0] CMD_ROW   = 8'h2B;
    localparam logic [7:0] CMD_MEMWR = 8'h2C;

    localparam logic [15:0] BG_COLOR_RESET = 16'hFFFF;

    localparam logic [1:0] MODE_WINDOW = 2'd0;
    localparam logic [1:0] MODE_FILL   = 2'd1;
    localparam logic [1:0] MODE_GLYPH  = 2'd2;

    // Byte positions inside the window sequence; unlisted positions are zero high bytes.
    localparam logic [5:0] WB_COL_CMD   = 6'd0;
    localparam logic [5:0] WB_X_START   = 6'd2;
    localparam logic [5:0] WB_X_LAST    = 6'd4;
    localparam logic [5:0] WB_ROW_CMD   = 6'd5;
    localparam logic [5:0] WB_Y_START   = 6'd7;
    localparam logic [5:0] WB_Y_LAST    = 6'd9;
    localparam logic [5:0] WB_MEMWR_CMD = 6'd10;

    typedef enum logic [1:0] {
        KIND_WINDOW,
        KIND_FILL,
        KIND_GLYPH
    } kind_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_end;
        logic [7:0]  y_end;
        logic [15:0] fore_color;
        logic [31:0] glyph_bits;
        logic [5:0]  pixel_count;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
    } result_t;

    // Classified work for the back end; last_idx is the index of the final byte.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  x_last;
        logic [7:0]  y_last;
        logic [15:0] color;
        logic [5:0]  last_idx;
    } cmd_t;

endpackage

`default_nettype wire

/* sv/lcdws_front.sv */
// Front end: accepts items, saturates counts, drops empty items, builds commands.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_front #(
    parameter int GLYPH_WORD_BITS = lcdws_pkg::GLYPH_WORD_BITS_DEF
) (
    input  wire lcdws_pkg::item_t         item,
    input  wire logic                     start,
    input  wire logic                     full,
    output lcdws_pkg::cmd_t               cmd,
    output logic [GLYPH_WORD_BITS-1:0]    bits,
    output logic                          push,
    output logic                          busy
);

    localparam int GLYPH_LIMIT = (GLYPH_WORD_BITS > lcdws_pkg::GLYPH_BITS_CAP) ?
                                 lcdws_pkg::GLYPH_BITS_CAP : GLYPH_WORD_BITS;
    localparam logic [5:0] GLYPH_LIMIT_C = 6'(GLYPH_LIMIT);
    localparam logic [5:0] RUN_LIMIT_C   = 6'(lcdws_pkg::RUN_MAX_PIXELS);

    logic [5:0] count_sat;
    logic [6:0] bytes_m1;
    logic       has_work;

    always_comb
    begin
        count_sat = 6'd0;
        has_work  = 1'b0;
        cmd.kind  = lcdws_pkg::KIND_WINDOW;
        case (item.mode)
            lcdws_pkg::MODE_WINDOW:
            begin
                has_work = 1'b1;
            end
            lcdws_pkg::MODE_FILL:
            begin
                cmd.kind  = lcdws_pkg::KIND_FILL;
                count_sat = (item.pixel_count > RUN_LIMIT_C) ? RUN_LIMIT_C : item.pixel_count;
                has_work  = (count_sat != 6'd0);
            end
            lcdws_pkg::MODE_GLYPH:
            begin
                cmd.kind  = lcdws_pkg::KIND_GLYPH;
                count_sat = (item.pixel_count > GLYPH_LIMIT_C) ? GLYPH_LIMIT_C :
                            item.pixel_count;
                has_work  = (count_sat != 6'd0);
            end
            default:
            begin
                has_work = 1'b0;
            end
        endcase

        // two bytes per pixel
        bytes_m1     = {count_sat, 1'b0} - 7'd1;
        cmd.last_idx = (item.mode == lcdws_pkg::MODE_WINDOW) ? lcdws_pkg::WB_MEMWR_CMD :
                       bytes_m1[5:0];
        cmd.x_start  = item.x_start;
        cmd.y_start  = item.y_start;
        cmd.x_last   = item.x_end - 8'd1;
        cmd.y_last   = item.y_end - 8'd1;
        cmd.color    = item.fore_color;
    end

    assign bits = item.glyph_bits[GLYPH_WORD_BITS-1:0];
    assign busy = full;
    assign push = start && !full && has_work;

endmodule

`default_nettype wire

/* sv/lcdws_queue.sv */
// Short register queue between front and back ends.
// Depends on lcdws_pkg for the depth.
`default_nettype none

module lcdws_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty,
    output logic                  full
);

    localparam int DEPTH = lcdws_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == CNT_FULL);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

/* sv/lcdws_back.sv */
// Back end: walks the queue head one byte per cycle, holds the background color.
// Depends on lcdws_pkg.
`default_nettype none

module lcdws_back #(
    parameter int GLYPH_WORD_BITS = lcdws_pkg::GLYPH_WORD_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         bg_color_we,
    input  wire logic [15:0]                  bg_color_wdata,
    input  wire logic                         empty,
    input  wire lcdws_pkg::cmd_t              cmd,
    input  wire logic [GLYPH_WORD_BITS-1:0]   bits,
    output logic                              pop,
    output lcdws_pkg::result_t                result,
    output logic                              strobe
);

    localparam int IDX_W = (GLYPH_WORD_BITS > 1) ? $clog2(GLYPH_WORD_BITS) : 1;

    logic [5:0]         cnt_reg, cnt_next;
    logic [15:0]        bg_color_reg;
    logic               strobe_reg, strobe_next;
    lcdws_pkg::result_t result_reg, result_next;
    logic [4:0]         pix;
    logic [IDX_W-1:0]   bit_idx;
    logic [15:0]        pix_color;

    assign pix     = cnt_reg[5:1];
    assign bit_idx = pix[IDX_W-1:0];
    assign pop     = !empty && (cnt_reg == cmd.last_idx);

    always_comb
    begin
        pix_color = cmd.color;
        if (cmd.kind == lcdws_pkg::KIND_GLYPH && !bits[bit_idx])
        begin
            pix_color = bg_color_reg;
        end

        result_next.is_data  = 1'b1;
        result_next.last     = pop;
        result_next.out_byte = cnt_reg[0] ? pix_color[7:0] : pix_color[15:8];
        if (cmd.kind == lcdws_pkg::KIND_WINDOW)
        begin
            case (cnt_reg)
                lcdws_pkg::WB_COL_CMD:
                begin
                    result_next.out_byte = lcdws_pkg::CMD_COL;
                    result_next.is_data  = 1'b0;
                end
                lcdws_pkg::WB_X_START:   result_next.out_byte = cmd.x_start;
                lcdws_pkg::WB_X_LAST:    result_next.out_byte = cmd.x_last;
                lcdws_pkg::WB_ROW_CMD:
                begin
                    result_next.out_byte = lcdws_pkg::CMD_ROW;
                    result_next.is_data  = 1'b0;
                end
                lcdws_pkg::WB_Y_START:   result_next.out_byte = cmd.y_start;
                lcdws_pkg::WB_Y_LAST:    result_next.out_byte = cmd.y_last;
                lcdws_pkg::WB_MEMWR_CMD:
                begin
                    result_next.out_byte = lcdws_pkg::CMD_MEMWR;
                    result_next.is_data  = 1'b0;
                end
                default:                 result_next.out_byte = 8'h00;
            endcase
        end

        strobe_next = !empty;
        cnt_next    = cnt_reg;
        if (pop)
        begin
            cnt_next = '0;
        end
        else if (!empty)
        begin
            cnt_next = cnt_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
            bg_color_reg <= lcdws_pkg::BG_COLOR_RESET;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            if (bg_color_we)
            begin
                bg_color_reg <= bg_color_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!empty)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

`default_nettype wire

/* sv/lcd_window_pixel_byte_streamer_top.sv */
// Back end idle: an item is written into the queue, then its first byte into the result register.
// Throughput: one byte per cycle; a window item is 11 bytes, a run or glyph 2 per pixel.
// A 2-entry queue parts front and back, so busy rises only when two items are pending.
// Items with no bytes (mode 3, zero count) are dropped at the front and never queued.
// Reset: queue empty, no strobe, background color = 0xFFFF.
// Depends on lcdws_pkg, lcdws_front, lcdws_queue, lcdws_back.
`default_nettype none

module lcd_window_pixel_byte_streamer_top #(
    parameter int GLYPH_WORD_BITS = lcdws_pkg::GLYPH_WORD_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item transfer: taken when start is high and busy is low
    input  wire logic               start,
    output logic                    busy,
    input  wire lcdws_pkg::item_t   item,
    // background color register
    input  wire logic               bg_color_we,
    input  wire logic [15:0]        bg_color_wdata,
    // one byte per strobe; the receiver cannot stall
    output logic                    strobe,
    output lcdws_pkg::result_t      result
);

    localparam int CMD_W   = $bits(lcdws_pkg::cmd_t);
    localparam int ENTRY_W = CMD_W + GLYPH_WORD_BITS;

    lcdws_pkg::cmd_t              front_cmd;
    logic [GLYPH_WORD_BITS-1:0]   front_bits;
    logic                         push;
    logic                         pop;
    logic                         q_empty;
    logic                         q_full;
    logic [ENTRY_W-1:0]           q_rdata;
    lcdws_pkg::cmd_t              head_cmd;
    logic [GLYPH_WORD_BITS-1:0]   head_bits;

    // Classify and drop empty items; hold off start while the queue is full.
    lcdws_front #(
        .GLYPH_WORD_BITS(GLYPH_WORD_BITS)
    ) u_front (
        .item  (item),
        .start (start),
        .full  (q_full),
        .cmd   (front_cmd),
        .bits  (front_bits),
        .push  (push),
        .busy  (busy)
    );

    // Decouple acceptance from byte generation.
    lcdws_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata ({front_cmd, front_bits}),
        .pop   (pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    assign head_cmd  = lcdws_pkg::cmd_t'(q_rdata[ENTRY_W-1:GLYPH_WORD_BITS]);
    assign head_bits = q_rdata[GLYPH_WORD_BITS-1:0];

    // Advance through the head item one byte per cycle, pop on its last byte.
    lcdws_back #(
        .GLYPH_WORD_BITS(GLYPH_WORD_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .bg_color_we    (bg_color_we),
        .bg_color_wdata (bg_color_wdata),
        .empty          (q_empty),
        .cmd            (head_cmd),
        .bits           (head_bits),
        .pop            (pop),
        .result         (result),
        .strobe         (strobe)
    );

endmodule

`default_nettype wire

/* sv/lcdws_checker.sv */
// Port-level checker for the LCD byte streamer, bound to the top level.
// Depends on lcdws_pkg and lcd_window_pixel_byte_streamer_top_assert.svh.
`default_nettype none
`include "lcd_window_pixel_byte_streamer_top_assert.svh"

module lcdws_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               strobe,
    input wire lcdws_pkg::result_t result
);

    logic is_col_cmd;
    logic is_row_cmd;
    logic is_memwr_cmd;

    assign is_col_cmd   = strobe && !result.is_data && (result.out_byte == lcdws_pkg::CMD_COL);
    assign is_row_cmd   = strobe && !result.is_data && (result.out_byte == lcdws_pkg::CMD_ROW);
    assign is_memwr_cmd = strobe && !result.is_data &&
                          (result.out_byte == lcdws_pkg::CMD_MEMWR);

    // bytes of one transfer leave without gaps
    `LCDWS_ASSERT_NEXT(a_no_gap, clk, rst_n, strobe && !result.last, strobe, "gap inside item")
    `LCDWS_ASSERT_NOW(a_memwr_last, clk, rst_n, is_memwr_cmd, result.last, "0x2C not last")
    `LCDWS_ASSERT_NOW(a_col_not_last, clk, rst_n, is_col_cmd, !result.last, "0x2A marked last")
    `LCDWS_ASSERT_NOW(a_row_after_col, clk, rst_n, is_row_cmd, $past(is_col_cmd, 5), "0x2B order")

endmodule

bind lcd_window_pixel_byte_streamer_top lcdws_checker u_lcdws_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .strobe (strobe),
    .result (result)
);

`default_nettype wire
